// ===== design/ncs_pkg.sv =====
// Shared types, constants and helpers for the natural cubic spline block.
`default_nettype none

package ncs_pkg;

  localparam int NUM_KNOTS = 16;
  localparam int IDX_W     = $clog2(NUM_KNOTS);

  // Divider: signed dividend, positive divisor, one quotient bit per cycle
  localparam int DIVN_W = 56;
  localparam int DIVD_W = 34;
  localparam int DCNT_W = $clog2(DIVN_W);

  localparam int ACC_W = 36;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BELOW    = 2'd1;
  localparam logic [1:0] ST_UNSOLVED = 2'd2;
  localparam logic [1:0] ST_EXTRAP   = 2'd3;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPACING = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST   = 1'd1;
  localparam logic [30:0] SPACING_RST = 31'd65536;

  typedef struct packed {
    logic               req_type;
    logic [3:0]         knot_index;
    logic signed [31:0] knot_value;
    logic               last_knot;
    logic signed [31:0] query_x;
  } req_t;

  typedef struct packed {
    logic signed [31:0] y_value;
    logic [1:0]         status;
  } result_t;

  typedef enum logic [5:0] {
    OP_NOP, OP_ACCEPT, OP_OUT_ZERO, OP_OUT_UNSOLVED, OP_OUT_BELOW, OP_OUT_Y,
    OP_Q_DIV, OP_Q_K, OP_Q_KH, OP_Q_DX, OP_Q_SQ, OP_Q_DX2, OP_Q_MCUBE, OP_Q_DX3,
    OP_Q_TB, OP_Q_TC, OP_Q_TD,
    OP_S_INIT, OP_S_RDK, OP_S_CAPA, OP_S_CAPB, OP_S_CAPC, OP_S_L, OP_S_ALPHA,
    OP_S_MUDIV, OP_S_MU, OP_S_ZDIV, OP_S_Z,
    OP_B_INIT, OP_B_RDK, OP_B_RD, OP_B_CAPA, OP_B_C0, OP_B_SLDIV, OP_B_SLOPE,
    OP_B_CVDIV, OP_B_B, OP_B_DDIV, OP_B_D, OP_S_DONE
  } dp_op_t;

  typedef enum logic [5:0] {
    ST_IDLE, ST_OUT0, ST_OUTNS, ST_OUTBL, ST_QOUT, ST_SDONE,
    ST_QCHK, ST_QDIV, ST_QDIVW, ST_QMK, ST_QDX, ST_QSQ, ST_QDX2, ST_QMC, ST_QDX3,
    ST_QTB, ST_QTC, ST_QTD,
    ST_SINIT, ST_F_RD, ST_F_CA, ST_F_CB, ST_F_CC, ST_F_L, ST_F_AW, ST_F_MD,
    ST_F_MW, ST_F_ZD, ST_F_ZW,
    ST_B_INIT, ST_B_RK, ST_B_RD, ST_B_CA, ST_B_C0, ST_B_SD, ST_B_SW, ST_B_CD,
    ST_B_BW, ST_B_DD, ST_B_DW
  } ctrl_state_t;

  typedef struct packed {
    dp_op_t           op;
    logic [IDX_W-1:0] addr;
  } dp_cmd_t;

  typedef struct packed {
    logic solved;
    logic t_neg;
    logic div_busy;
  } dp_stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage

`default_nettype wire

// ===== design/ncs_div.sv =====
// Restoring divider: truncating signed quotient, saturated to 32 bits.
`default_nettype none

module ncs_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [ncs_pkg::DIVN_W-1:0] dividend,
  input  logic [ncs_pkg::DIVD_W-1:0]        divisor,
  output logic                              busy,
  output logic signed [31:0]                quot
);

  localparam logic [ncs_pkg::DIVN_W-1:0] POS_MAX = ncs_pkg::DIVN_W'(64'h7fffffff);

  logic [ncs_pkg::DIVN_W-1:0] qm;
  logic [ncs_pkg::DIVN_W-1:0] mag;
  logic [ncs_pkg::DIVD_W-1:0] rem;
  logic [ncs_pkg::DIVD_W-1:0] dvs;
  logic [ncs_pkg::DIVD_W:0]   trial;
  logic [ncs_pkg::DIVD_W:0]   diff;
  logic                       neg;
  logic [ncs_pkg::DCNT_W-1:0] cnt;

  assign mag   = dividend[ncs_pkg::DIVN_W-1] ? ncs_pkg::DIVN_W'(-dividend)
                                             : ncs_pkg::DIVN_W'(dividend);
  assign trial = {rem, qm[ncs_pkg::DIVN_W-1]};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= ncs_pkg::DCNT_W'(ncs_pkg::DIVN_W - 1);
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
      end
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      qm  <= mag;
      rem <= '0;
      dvs <= divisor;
      neg <= dividend[ncs_pkg::DIVN_W-1];
    end else if (busy) begin
      if (trial >= {1'b0, dvs}) begin
        rem <= diff[ncs_pkg::DIVD_W-1:0];
        qm  <= {qm[ncs_pkg::DIVN_W-2:0], 1'b1};
      end else begin
        rem <= trial[ncs_pkg::DIVD_W-1:0];
        qm  <= {qm[ncs_pkg::DIVN_W-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    if (!neg) begin
      quot = (qm > POS_MAX) ? 32'sh7fffffff : signed'(qm[31:0]);
    end else begin
      quot = (qm > POS_MAX + 1'b1) ? 32'sh80000000 : signed'(-qm[31:0]);
    end
  end

endmodule

`default_nettype wire

// ===== design/ncs_dp.sv =====
// Datapath: knot and coefficient memories, multiplier, divider, result register.
`default_nettype none

module ncs_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  ncs_pkg::dp_cmd_t                 cmd,
  output ncs_pkg::dp_stat_t                stat,
  input  ncs_pkg::req_t                    req,
  input  logic                             cfg_we,
  input  logic [ncs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [31:0]                      cfg_data,
  output logic                             done,
  output ncs_pkg::result_t                 result
);

  localparam int N  = ncs_pkg::NUM_KNOTS;
  localparam int IW = ncs_pkg::IDX_W;

  logic signed [31:0] knot_mem [N];
  logic signed [31:0] b_mem    [N];
  logic signed [31:0] c_mem    [N];
  logic signed [31:0] d_mem    [N];
  logic signed [31:0] mu_mem   [N];
  logic signed [31:0] z_mem    [N];
  logic signed [31:0] kq, bq, cq, dq, muq, zq;

  logic [30:0]        spacing;
  logic signed [31:0] first;
  logic               solved;
  logic               over;
  logic signed [32:0] t;
  logic [IW-1:0]      kreg;
  logic signed [31:0] dx, dx2, dx3;
  logic signed [ncs_pkg::ACC_W-1:0] acc;
  logic signed [31:0] ka, kb, kc, mu_p, z_p, lreg, alpha, c1, c0;
  logic signed [63:0] prod;

  logic [31:0]        h_u;
  logic signed [31:0] h_s;
  logic signed [63:0] prod_adj;
  logic signed [31:0] mq;
  logic signed [31:0] mul_a, mul_b;
  logic               mul_en;
  logic               div_start, div_busy;
  logic signed [ncs_pkg::DIVN_W-1:0] div_num;
  logic [ncs_pkg::DIVD_W-1:0]        div_den;
  logic signed [31:0] divq;
  logic [IW-1:0]      rd_addr;
  logic signed [34:0] d2;
  logic signed [36:0] d3;
  logic signed [31:0] l_sat, l_pos, c0_n, cv;
  logic [31:0]        cv_mag;
  logic [63:0]        cv_rcp;
  logic signed [31:0] cv_q, curv;

  assign h_u = (spacing == '0) ? 32'd1 : {1'b0, spacing};
  assign h_s = signed'(h_u);

  // Q16.16 product, truncated toward zero
  assign prod_adj = prod + (prod[63] ? 64'sd65535 : 64'sd0);
  assign mq       = ncs_pkg::sat32(prod_adj >>> 16);

  assign d2    = 35'(kc) - (35'(kb) <<< 1) + 35'(ka);
  assign d3    = 37'(d2) + (37'(d2) <<< 1);
  assign l_sat = ncs_pkg::sat32((64'(h_s) <<< 2) - 64'(mq));
  assign l_pos = (l_sat <= 32'sd0) ? 32'sd1 : l_sat;
  assign c0_n  = ncs_pkg::sat32(64'(zq) - 64'(mq));
  assign cv    = ncs_pkg::sat32(64'(c1) + (64'(c0) <<< 1));

  // divide by three toward zero: magnitude times ceil(2^33 / 3), then shift
  assign cv_mag = mq[31] ? unsigned'(-mq) : unsigned'(mq);
  assign cv_rcp = 64'(cv_mag) * 64'(32'haaaaaaab);
  assign cv_q   = mq[31] ? -signed'({1'b0, cv_rcp[63:33]}) : signed'({1'b0, cv_rcp[63:33]});

  assign rd_addr = (cmd.op == ncs_pkg::OP_Q_KH) ? kreg : cmd.addr;

  assign stat.solved   = solved;
  assign stat.t_neg    = t[32];
  assign stat.div_busy = div_busy;

  ncs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .busy     (div_busy),
    .quot     (divq)
  );

  always_comb begin
    mul_en = 1'b1;
    mul_a  = h_s;
    mul_b  = mu_p;
    case (cmd.op)
      ncs_pkg::OP_S_CAPC:  begin mul_a = h_s;  mul_b = mu_p; end
      ncs_pkg::OP_S_MU:    begin mul_a = h_s;  mul_b = z_p;  end
      ncs_pkg::OP_B_CAPA:  begin mul_a = muq;  mul_b = c1;   end
      ncs_pkg::OP_B_SLDIV: begin mul_a = h_s;  mul_b = cv;   end
      ncs_pkg::OP_Q_KH:    begin mul_a = 32'(kreg); mul_b = h_s; end
      ncs_pkg::OP_Q_SQ:    begin mul_a = dx;   mul_b = dx;   end
      ncs_pkg::OP_Q_MCUBE: begin mul_a = dx2;  mul_b = dx;   end
      ncs_pkg::OP_Q_DX3:   begin mul_a = bq;   mul_b = dx;   end
      ncs_pkg::OP_Q_TB:    begin mul_a = cq;   mul_b = dx2;  end
      ncs_pkg::OP_Q_TC:    begin mul_a = dq;   mul_b = dx3;  end
      default:             mul_en = 1'b0;
    endcase
  end

  always_comb begin
    div_start = 1'b1;
    div_num   = ncs_pkg::DIVN_W'(t);
    div_den   = ncs_pkg::DIVD_W'(h_u);
    case (cmd.op)
      ncs_pkg::OP_Q_DIV: begin
        div_num = ncs_pkg::DIVN_W'(t);
      end
      ncs_pkg::OP_S_L: begin
        div_num = ncs_pkg::DIVN_W'(d3) <<< 16;
      end
      ncs_pkg::OP_S_MUDIV: begin
        div_num = ncs_pkg::DIVN_W'(h_s) <<< 16;
        div_den = ncs_pkg::DIVD_W'(unsigned'(lreg));
      end
      ncs_pkg::OP_S_ZDIV: begin
        div_num = ncs_pkg::DIVN_W'(ncs_pkg::sat32(64'(alpha) - 64'(mq))) <<< 16;
        div_den = ncs_pkg::DIVD_W'(unsigned'(lreg));
      end
      ncs_pkg::OP_B_SLDIV: begin
        div_num = ncs_pkg::DIVN_W'(ncs_pkg::sat32(64'(kb) - 64'(ka))) <<< 16;
      end
      ncs_pkg::OP_B_DDIV: begin
        div_num = ncs_pkg::DIVN_W'(33'(c1) - 33'(c0)) <<< 16;
        div_den = ncs_pkg::DIVD_W'(h_u) + (ncs_pkg::DIVD_W'(h_u) << 1);
      end
      default: div_start = 1'b0;
    endcase
  end

  // configuration and control flags
  always_ff @(posedge clk) begin
    if (rst) begin
      spacing <= ncs_pkg::SPACING_RST;
      first   <= '0;
      solved  <= 1'b0;
      done    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          ncs_pkg::CFG_SPACING: spacing <= cfg_data[30:0];
          ncs_pkg::CFG_FIRST:   first   <= signed'(cfg_data);
          default:              ;
        endcase
      end
      if (cmd.op == ncs_pkg::OP_S_DONE) begin
        solved <= 1'b1;
      end
      done <= (cmd.op == ncs_pkg::OP_OUT_ZERO) || (cmd.op == ncs_pkg::OP_OUT_UNSOLVED)
           || (cmd.op == ncs_pkg::OP_OUT_BELOW) || (cmd.op == ncs_pkg::OP_OUT_Y)
           || (cmd.op == ncs_pkg::OP_S_DONE);
    end
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= 64'(mul_a) * 64'(mul_b);
    end
    case (cmd.op)
      ncs_pkg::OP_ACCEPT: t <= 33'(req.query_x) - 33'(first);
      ncs_pkg::OP_Q_DIV:  over <= (64'(t) > 64'(h_s) * 64'(N - 1));
      ncs_pkg::OP_Q_K: begin
        if (divq > 32'(N - 2)) begin
          kreg <= IW'(N - 2);
        end else begin
          kreg <= divq[IW-1:0];
        end
      end
      ncs_pkg::OP_Q_DX:   dx  <= ncs_pkg::sat32(64'(t) - prod);
      ncs_pkg::OP_Q_DX2:  dx2 <= mq;
      ncs_pkg::OP_Q_DX3:  dx3 <= mq;
      ncs_pkg::OP_Q_TB:   acc <= ncs_pkg::ACC_W'(kq) + ncs_pkg::ACC_W'(mq);
      ncs_pkg::OP_Q_TC,
      ncs_pkg::OP_Q_TD:   acc <= acc + ncs_pkg::ACC_W'(mq);
      ncs_pkg::OP_S_INIT: begin
        mu_p <= '0;
        z_p  <= '0;
      end
      ncs_pkg::OP_S_CAPA: ka <= kq;
      ncs_pkg::OP_S_CAPB: kb <= kq;
      ncs_pkg::OP_S_CAPC: kc <= kq;
      ncs_pkg::OP_S_L:    lreg <= l_pos;
      ncs_pkg::OP_S_ALPHA,
      ncs_pkg::OP_B_SLOPE: alpha <= divq;
      ncs_pkg::OP_S_MU:   mu_p <= divq;
      ncs_pkg::OP_S_Z:    z_p  <= divq;
      ncs_pkg::OP_B_INIT: c1 <= '0;
      ncs_pkg::OP_B_RD:   kb <= kq;
      ncs_pkg::OP_B_CAPA: ka <= kq;
      ncs_pkg::OP_B_C0:   c0 <= c0_n;
      ncs_pkg::OP_B_CVDIV: curv <= cv_q;
      ncs_pkg::OP_B_D:    c1 <= c0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      ncs_pkg::OP_OUT_ZERO,
      ncs_pkg::OP_S_DONE:       result <= '{y_value: '0, status: ncs_pkg::ST_OK};
      ncs_pkg::OP_OUT_UNSOLVED: result <= '{y_value: '0, status: ncs_pkg::ST_UNSOLVED};
      ncs_pkg::OP_OUT_BELOW:    result <= '{y_value: '0, status: ncs_pkg::ST_BELOW};
      ncs_pkg::OP_OUT_Y: begin
        result.y_value <= ncs_pkg::sat32(64'(acc));
        result.status  <= over ? ncs_pkg::ST_EXTRAP : ncs_pkg::ST_OK;
      end
      default: ;
    endcase
  end

  // knot values
  always_ff @(posedge clk) begin
    if (cmd.op == ncs_pkg::OP_ACCEPT && req.req_type == ncs_pkg::REQ_LOAD
        && int'(req.knot_index) < N) begin
      knot_mem[IW'(req.knot_index)] <= req.knot_value;
    end
    if (cmd.op == ncs_pkg::OP_S_RDK || cmd.op == ncs_pkg::OP_S_CAPA
        || cmd.op == ncs_pkg::OP_S_CAPB || cmd.op == ncs_pkg::OP_B_RDK
        || cmd.op == ncs_pkg::OP_B_RD || cmd.op == ncs_pkg::OP_Q_KH) begin
      kq <= knot_mem[rd_addr];
    end
  end

  // sweep terms
  always_ff @(posedge clk) begin
    if (cmd.op == ncs_pkg::OP_S_INIT) begin
      mu_mem[0] <= '0;
      z_mem[0]  <= '0;
    end
    if (cmd.op == ncs_pkg::OP_S_MU) begin
      mu_mem[cmd.addr] <= divq;
    end
    if (cmd.op == ncs_pkg::OP_S_Z) begin
      z_mem[cmd.addr] <= divq;
    end
    if (cmd.op == ncs_pkg::OP_B_RD) begin
      muq <= mu_mem[rd_addr];
      zq  <= z_mem[rd_addr];
    end
  end

  // coefficients
  always_ff @(posedge clk) begin
    if (cmd.op == ncs_pkg::OP_B_C0) begin
      c_mem[cmd.addr] <= c0_n;
    end
    if (cmd.op == ncs_pkg::OP_B_B) begin
      b_mem[cmd.addr] <= ncs_pkg::sat32(64'(alpha) - 64'(curv));
    end
    if (cmd.op == ncs_pkg::OP_B_D) begin
      d_mem[cmd.addr] <= divq;
    end
    if (cmd.op == ncs_pkg::OP_Q_KH) begin
      bq <= b_mem[rd_addr];
      cq <= c_mem[rd_addr];
      dq <= d_mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== design/ncs_ctrl.sv =====
// Controller: sequences loads, queries and the coefficient solve.
`default_nettype none

module ncs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              is_load,
  input  logic              is_last,
  input  ncs_pkg::dp_stat_t stat,
  output ncs_pkg::dp_cmd_t  cmd,
  output logic              busy
);

  localparam int IW = ncs_pkg::IDX_W;

  ncs_pkg::ctrl_state_t state, state_next;
  logic [IW-1:0] idx;

  assign busy = (state != ncs_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ncs_pkg::ST_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      case (state)
        ncs_pkg::ST_SINIT:  idx <= IW'(1);
        ncs_pkg::ST_F_ZW:   if (!stat.div_busy) idx <= idx + 1'b1;
        ncs_pkg::ST_B_INIT: idx <= IW'(ncs_pkg::NUM_KNOTS - 2);
        ncs_pkg::ST_B_DW:   if (!stat.div_busy) idx <= idx - 1'b1;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ncs_pkg::ST_IDLE: begin
        if (start) begin
          if (is_load) begin
            state_next = is_last ? ncs_pkg::ST_SINIT : ncs_pkg::ST_OUT0;
          end else begin
            state_next = ncs_pkg::ST_QCHK;
          end
        end
      end
      ncs_pkg::ST_OUT0, ncs_pkg::ST_OUTNS, ncs_pkg::ST_OUTBL,
      ncs_pkg::ST_QOUT, ncs_pkg::ST_SDONE: state_next = ncs_pkg::ST_IDLE;
      ncs_pkg::ST_QCHK: begin
        if (!stat.solved) begin
          state_next = ncs_pkg::ST_OUTNS;
        end else if (stat.t_neg) begin
          state_next = ncs_pkg::ST_OUTBL;
        end else begin
          state_next = ncs_pkg::ST_QDIV;
        end
      end
      ncs_pkg::ST_QDIV:  state_next = ncs_pkg::ST_QDIVW;
      ncs_pkg::ST_QDIVW: if (!stat.div_busy) state_next = ncs_pkg::ST_QMK;
      ncs_pkg::ST_QMK:   state_next = ncs_pkg::ST_QDX;
      ncs_pkg::ST_QDX:   state_next = ncs_pkg::ST_QSQ;
      ncs_pkg::ST_QSQ:   state_next = ncs_pkg::ST_QDX2;
      ncs_pkg::ST_QDX2:  state_next = ncs_pkg::ST_QMC;
      ncs_pkg::ST_QMC:   state_next = ncs_pkg::ST_QDX3;
      ncs_pkg::ST_QDX3:  state_next = ncs_pkg::ST_QTB;
      ncs_pkg::ST_QTB:   state_next = ncs_pkg::ST_QTC;
      ncs_pkg::ST_QTC:   state_next = ncs_pkg::ST_QTD;
      ncs_pkg::ST_QTD:   state_next = ncs_pkg::ST_QOUT;
      ncs_pkg::ST_SINIT: state_next = ncs_pkg::ST_F_RD;
      ncs_pkg::ST_F_RD:  state_next = ncs_pkg::ST_F_CA;
      ncs_pkg::ST_F_CA:  state_next = ncs_pkg::ST_F_CB;
      ncs_pkg::ST_F_CB:  state_next = ncs_pkg::ST_F_CC;
      ncs_pkg::ST_F_CC:  state_next = ncs_pkg::ST_F_L;
      ncs_pkg::ST_F_L:   state_next = ncs_pkg::ST_F_AW;
      ncs_pkg::ST_F_AW:  if (!stat.div_busy) state_next = ncs_pkg::ST_F_MD;
      ncs_pkg::ST_F_MD:  state_next = ncs_pkg::ST_F_MW;
      ncs_pkg::ST_F_MW:  if (!stat.div_busy) state_next = ncs_pkg::ST_F_ZD;
      ncs_pkg::ST_F_ZD:  state_next = ncs_pkg::ST_F_ZW;
      ncs_pkg::ST_F_ZW: begin
        if (!stat.div_busy) begin
          state_next = (idx == IW'(ncs_pkg::NUM_KNOTS - 2)) ? ncs_pkg::ST_B_INIT
                                                             : ncs_pkg::ST_F_RD;
        end
      end
      ncs_pkg::ST_B_INIT: state_next = ncs_pkg::ST_B_RK;
      ncs_pkg::ST_B_RK:   state_next = ncs_pkg::ST_B_RD;
      ncs_pkg::ST_B_RD:   state_next = ncs_pkg::ST_B_CA;
      ncs_pkg::ST_B_CA:   state_next = ncs_pkg::ST_B_C0;
      ncs_pkg::ST_B_C0:   state_next = ncs_pkg::ST_B_SD;
      ncs_pkg::ST_B_SD:   state_next = ncs_pkg::ST_B_SW;
      ncs_pkg::ST_B_SW:   if (!stat.div_busy) state_next = ncs_pkg::ST_B_CD;
      ncs_pkg::ST_B_CD:   state_next = ncs_pkg::ST_B_BW;
      ncs_pkg::ST_B_BW:   if (!stat.div_busy) state_next = ncs_pkg::ST_B_DD;
      ncs_pkg::ST_B_DD:   state_next = ncs_pkg::ST_B_DW;
      ncs_pkg::ST_B_DW: begin
        if (!stat.div_busy) begin
          state_next = (idx == '0) ? ncs_pkg::ST_SDONE : ncs_pkg::ST_B_RK;
        end
      end
      default: state_next = ncs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.op   = ncs_pkg::OP_NOP;
    cmd.addr = idx;
    case (state)
      ncs_pkg::ST_IDLE:   if (start) cmd.op = ncs_pkg::OP_ACCEPT;
      ncs_pkg::ST_OUT0:   cmd.op = ncs_pkg::OP_OUT_ZERO;
      ncs_pkg::ST_OUTNS:  cmd.op = ncs_pkg::OP_OUT_UNSOLVED;
      ncs_pkg::ST_OUTBL:  cmd.op = ncs_pkg::OP_OUT_BELOW;
      ncs_pkg::ST_QOUT:   cmd.op = ncs_pkg::OP_OUT_Y;
      ncs_pkg::ST_SDONE:  cmd.op = ncs_pkg::OP_S_DONE;
      ncs_pkg::ST_QCHK:   cmd.op = ncs_pkg::OP_NOP;
      ncs_pkg::ST_QDIV:   cmd.op = ncs_pkg::OP_Q_DIV;
      ncs_pkg::ST_QDIVW:  if (!stat.div_busy) cmd.op = ncs_pkg::OP_Q_K;
      ncs_pkg::ST_QMK:    cmd.op = ncs_pkg::OP_Q_KH;
      ncs_pkg::ST_QDX:    cmd.op = ncs_pkg::OP_Q_DX;
      ncs_pkg::ST_QSQ:    cmd.op = ncs_pkg::OP_Q_SQ;
      ncs_pkg::ST_QDX2:   cmd.op = ncs_pkg::OP_Q_DX2;
      ncs_pkg::ST_QMC:    cmd.op = ncs_pkg::OP_Q_MCUBE;
      ncs_pkg::ST_QDX3:   cmd.op = ncs_pkg::OP_Q_DX3;
      ncs_pkg::ST_QTB:    cmd.op = ncs_pkg::OP_Q_TB;
      ncs_pkg::ST_QTC:    cmd.op = ncs_pkg::OP_Q_TC;
      ncs_pkg::ST_QTD:    cmd.op = ncs_pkg::OP_Q_TD;
      ncs_pkg::ST_SINIT:  cmd.op = ncs_pkg::OP_S_INIT;
      ncs_pkg::ST_F_RD: begin
        cmd.op   = ncs_pkg::OP_S_RDK;
        cmd.addr = idx - 1'b1;
      end
      ncs_pkg::ST_F_CA:   cmd.op = ncs_pkg::OP_S_CAPA;
      ncs_pkg::ST_F_CB: begin
        cmd.op   = ncs_pkg::OP_S_CAPB;
        cmd.addr = idx + 1'b1;
      end
      ncs_pkg::ST_F_CC:   cmd.op = ncs_pkg::OP_S_CAPC;
      ncs_pkg::ST_F_L:    cmd.op = ncs_pkg::OP_S_L;
      ncs_pkg::ST_F_AW:   if (!stat.div_busy) cmd.op = ncs_pkg::OP_S_ALPHA;
      ncs_pkg::ST_F_MD:   cmd.op = ncs_pkg::OP_S_MUDIV;
      ncs_pkg::ST_F_MW:   if (!stat.div_busy) cmd.op = ncs_pkg::OP_S_MU;
      ncs_pkg::ST_F_ZD:   cmd.op = ncs_pkg::OP_S_ZDIV;
      ncs_pkg::ST_F_ZW:   if (!stat.div_busy) cmd.op = ncs_pkg::OP_S_Z;
      ncs_pkg::ST_B_INIT: cmd.op = ncs_pkg::OP_B_INIT;
      ncs_pkg::ST_B_RK: begin
        cmd.op   = ncs_pkg::OP_B_RDK;
        cmd.addr = idx + 1'b1;
      end
      ncs_pkg::ST_B_RD:   cmd.op = ncs_pkg::OP_B_RD;
      ncs_pkg::ST_B_CA:   cmd.op = ncs_pkg::OP_B_CAPA;
      ncs_pkg::ST_B_C0:   cmd.op = ncs_pkg::OP_B_C0;
      ncs_pkg::ST_B_SD:   cmd.op = ncs_pkg::OP_B_SLDIV;
      ncs_pkg::ST_B_SW:   if (!stat.div_busy) cmd.op = ncs_pkg::OP_B_SLOPE;
      ncs_pkg::ST_B_CD:   cmd.op = ncs_pkg::OP_B_CVDIV;
      ncs_pkg::ST_B_BW:   if (!stat.div_busy) cmd.op = ncs_pkg::OP_B_B;
      ncs_pkg::ST_B_DD:   cmd.op = ncs_pkg::OP_B_DDIV;
      ncs_pkg::ST_B_DW:   if (!stat.div_busy) cmd.op = ncs_pkg::OP_B_D;
      default:            cmd.op = ncs_pkg::OP_NOP;
    endcase
  end

endmodule

`default_nettype wire

// ===== design/natural_cubic_spline_uniform_top.sv =====
// Top level of the uniform-knot natural cubic spline interpolator.
//
//   channel   signals                                   direction
//   request   start, busy, req                          in (busy out)
//   result    done, result                              out
//   config    cfg_valid, cfg_ready, cfg_index, cfg_data in (cfg_ready out)
//
// A load without the last mark passes through ST_OUT0 before its result shows.
// A flagged query goes from ST_QCHK straight to an output state; a full query
// waits on one pass of the serial divider and then runs the multiply chain.
// A load marked last runs the solve: 14 forward steps (three divisions each)
// and 15 back steps (two divisions each) before its result shows. Register
// writes wait while busy.
// Reset is synchronous; it clears the solved flag and the registers to defaults.
// Results are shown for one cycle on done; the receiver cannot stall them.
`default_nettype none

module natural_cubic_spline_uniform_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  ncs_pkg::req_t                 req,
  output logic                          done,
  output ncs_pkg::result_t              result,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ncs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data
);

  ncs_pkg::dp_cmd_t  cmd;
  ncs_pkg::dp_stat_t stat;

  assign cfg_ready = !busy;

  ncs_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .is_load (req.req_type == ncs_pkg::REQ_LOAD),
    .is_last (req.last_knot),
    .stat    (stat),
    .cmd     (cmd),
    .busy    (busy)
  );

  ncs_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .req       (req),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .done      (done),
    .result    (result)
  );

  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held for two cycles");

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result shown while still busy");

  a_accept_no_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> !done)
    else $error("result in the cycle after an item was taken");

  a_flag_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status == ncs_pkg::ST_BELOW || result.status == ncs_pkg::ST_UNSOLVED))
    |-> (result.y_value == 32'sd0))
    else $error("flagged query with nonzero value");

endmodule

`default_nettype wire

// ===== sim/tb_natural_cubic_spline_uniform_top.sv =====
// Self-checking testbench for the uniform-knot natural cubic spline block.
`timescale 1ns / 100ps

module tb_natural_cubic_spline_uniform_top;

  localparam int WATCHDOG_CYCLES = 40000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  ncs_pkg::req_t req = '0;
  logic done;
  ncs_pkg::result_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [ncs_pkg::CFG_IDX_W-1:0] cfg_index = ncs_pkg::CFG_SPACING;
  logic [31:0] cfg_data = '0;

  natural_cubic_spline_uniform_top uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req), .done(done),
    .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // spline state as the block should hold it
  int knots [ncs_pkg::NUM_KNOTS];
  int slope_b [ncs_pkg::NUM_KNOTS];
  int curv_c [ncs_pkg::NUM_KNOTS];
  int cubic_d [ncs_pkg::NUM_KNOTS];
  int sweep_m [ncs_pkg::NUM_KNOTS];
  int sweep_zz [ncs_pkg::NUM_KNOTS];
  bit have_coefs = 1'b0;
  logic [30:0] spacing_reg = ncs_pkg::SPACING_RST;
  int first_reg = 0;

  ncs_pkg::req_t pending_items[$];
  ncs_pkg::result_t expected_results[$];
  bit item_taken = 1'b0;
  int idle_pct = 36;
  int mismatches = 0;
  int checked = 0;
  int solves = 0;
  int n_ok = 0, n_below = 0, n_unsolved = 0, n_extrap = 0;
  int quiet_cycles = 0;

  function automatic int sat(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return int'(v);
  endfunction

  function automatic int qmul(input int u, input int v);
    return sat((longint'(u) * longint'(v)) / 65536);
  endfunction

  function automatic int qdiv(input int u, input longint v);
    return sat((longint'(u) * 65536) / v);
  endfunction

  function automatic int eff_spacing();
    return (spacing_reg == 0) ? 1 : int'({1'b0, spacing_reg});
  endfunction

  function automatic void solve_coefs();
    int h, alpha, l, c0, c1, slope, curv;
    longint d2;
    h = eff_spacing();
    sweep_m[0] = 0;
    sweep_zz[0] = 0;
    for (int i = 1; i < ncs_pkg::NUM_KNOTS - 1; i++) begin
      d2 = longint'(knots[i+1]) - 2 * longint'(knots[i]) + longint'(knots[i-1]);
      alpha = sat((3 * d2 * 65536) / h);
      l = sat(4 * longint'(h) - qmul(h, sweep_m[i-1]));
      if (l <= 0) l = 1;
      sweep_m[i] = qdiv(h, l);
      sweep_zz[i] = qdiv(sat(longint'(alpha) - qmul(h, sweep_zz[i-1])), l);
    end
    curv_c[ncs_pkg::NUM_KNOTS-1] = 0;
    for (int i = ncs_pkg::NUM_KNOTS - 2; i >= 0; i--) begin
      c1 = curv_c[i+1];
      c0 = sat(longint'(sweep_zz[i]) - qmul(sweep_m[i], c1));
      slope = qdiv(sat(longint'(knots[i+1]) - knots[i]), h);
      curv = qmul(h, sat(longint'(c1) + 2 * longint'(c0))) / 3;
      curv_c[i] = c0;
      slope_b[i] = sat(longint'(slope) - curv);
      cubic_d[i] = sat(((longint'(c1) - c0) * 65536) / (3 * longint'(h)));
    end
    have_coefs = 1'b1;
  endfunction

  function automatic ncs_pkg::result_t predict_result(input ncs_pkg::req_t it);
    ncs_pkg::result_t r;
    int h, dx, dx2, dx3;
    longint t, k, sum;
    r = '0;
    if (it.req_type == ncs_pkg::REQ_LOAD) begin
      knots[it.knot_index] = it.knot_value;
      if (it.last_knot) solve_coefs();
    end else if (!have_coefs) begin
      r.status = ncs_pkg::ST_UNSOLVED;
    end else begin
      h = eff_spacing();
      t = longint'(it.query_x) - first_reg;
      if (t < 0) begin
        r.status = ncs_pkg::ST_BELOW;
      end else begin
        k = t / h;
        r.status = (t > longint'(ncs_pkg::NUM_KNOTS - 1) * h) ? ncs_pkg::ST_EXTRAP
                                                              : ncs_pkg::ST_OK;
        if (k > ncs_pkg::NUM_KNOTS - 2) k = ncs_pkg::NUM_KNOTS - 2;
        dx = sat(t - k * h);
        dx2 = qmul(dx, dx);
        dx3 = qmul(dx2, dx);
        sum = longint'(knots[k]) + qmul(slope_b[k], dx) + qmul(curv_c[k], dx2)
              + qmul(cubic_d[k], dx3);
        r.y_value = sat(sum);
      end
    end
    return r;
  endfunction

  // driver: present the next item at the falling edge
  always @(negedge clk) begin
    if (!rst && (!start || item_taken)) begin
      if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
        req <= pending_items.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: check results, predict accepted items, track register writes
  always @(posedge clk) begin
    ncs_pkg::result_t exp_r;
    bit active;
    bit taken;
    active = 1'b0;
    taken = 1'b0;
    if (!rst) begin
      if (done) begin
        active = 1'b1;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", result);
        end else begin
          exp_r = expected_results.pop_front();
          checked++;
          if (result.y_value !== exp_r.y_value || result.status !== exp_r.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: y_value exp %h got %h, status exp %0d got %0d",
                       exp_r.y_value, result.y_value, exp_r.status, result.status);
          end
          case (exp_r.status)
            ncs_pkg::ST_OK: n_ok++;
            ncs_pkg::ST_BELOW: n_below++;
            ncs_pkg::ST_UNSOLVED: n_unsolved++;
            default: n_extrap++;
          endcase
        end
      end
      if (start && !busy) begin
        active = 1'b1;
        taken = 1'b1;
        if (req.req_type == ncs_pkg::REQ_LOAD && req.last_knot) solves++;
        expected_results.push_back(predict_result(req));
      end
      if (cfg_valid && cfg_ready) begin
        active = 1'b1;
        if (cfg_index == ncs_pkg::CFG_SPACING) spacing_reg = cfg_data[30:0];
        else first_reg = cfg_data;
      end
      if (quiet_cycles >= WATCHDOG_CYCLES) begin
        $display("Some tests failed");
        $finish;
      end
      quiet_cycles <= active ? 0 : quiet_cycles + 1;
    end
    item_taken <= taken;
  end

  // generator side: mirror of the knot write mask and register settings
  bit [ncs_pkg::NUM_KNOTS-1:0] loaded = '0;
  longint gen_h = 65536;
  longint gen_first = 0;

  function automatic int clamp(input longint v);
    return sat(v);
  endfunction

  function automatic ncs_pkg::req_t load_item(input int idx, input int val, input bit last);
    ncs_pkg::req_t it;
    it = '0;
    it.req_type = ncs_pkg::REQ_LOAD;
    it.knot_index = 4'(idx);
    it.knot_value = val;
    it.last_knot = last;
    it.query_x = $urandom;
    return it;
  endfunction

  function automatic ncs_pkg::req_t query_item(input int x);
    ncs_pkg::req_t it;
    it = '0;
    it.req_type = ncs_pkg::REQ_QUERY;
    it.knot_index = 4'($urandom);
    it.knot_value = $urandom;
    it.last_knot = 1'($urandom);
    it.query_x = x;
    return it;
  endfunction

  task automatic push_load(input int idx, input int val, input bit last);
    loaded[idx] = 1'b1;
    pending_items.push_back(load_item(idx, val, last && (&loaded)));
  endtask

  task automatic push_random();
    int sel;
    longint hh;
    hh = (gen_h == 0) ? 1 : gen_h;
    if ($urandom_range(99) < 45) begin
      sel = $urandom_range(9);
      if (sel < 6)
        pending_items.push_back(query_item(clamp(gen_first + $urandom_range(0, 15) * hh
                                                 + ($urandom % hh))));
      else if (sel == 6)
        pending_items.push_back(query_item(clamp(gen_first - $urandom_range(1, 70000))));
      else if (sel == 7)
        pending_items.push_back(query_item(clamp(gen_first + 15 * hh
                                                 + $urandom_range(0, 200000))));
      else
        pending_items.push_back(query_item($urandom));
    end else begin
      push_load($urandom_range(ncs_pkg::NUM_KNOTS - 1),
                ($urandom_range(99) < 85) ? int'($urandom_range(0, 1 << 20)) - (1 << 19)
                                          : int'($urandom),
                $urandom_range(29) == 0);
    end
  endtask

  task automatic wait_drained();
    wait (pending_items.size() == 0 && !start && expected_results.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ncs_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == ncs_pkg::CFG_SPACING) gen_h = val[30:0];
    else gen_first = longint'(int'(val));
  endtask

  initial begin
    logic [31:0] spc_set [4];
    logic [31:0] first_set [4];
    spc_set = '{32'd32768, 32'd1, 32'h7fffffff, 32'd0};
    first_set = '{-32'sd327680, 32'h80000000, 32'h80000000, 32'd100};
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: unsolved queries, extreme knots, edges of the knot range
    pending_items.push_back(query_item(0));
    pending_items.push_back(query_item(32'h80000000));
    for (int i = 0; i < ncs_pkg::NUM_KNOTS; i++)
      push_load(i, (i == 3) ? 32'h7fffffff : (i == 4) ? 32'h80000000 : i << 16,
                i == ncs_pkg::NUM_KNOTS - 1);
    pending_items.push_back(query_item(0));
    pending_items.push_back(query_item(15 << 16));
    pending_items.push_back(query_item((15 << 16) + 5));
    pending_items.push_back(query_item(-1));
    pending_items.push_back(query_item(32'h7fffffff));
    push_load(2, 32'h00030000, 1'b0);
    pending_items.push_back(query_item(2 << 16));
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph < 2) ? 36 : (ph == 2) ? 65 : 0;
      write_reg(ncs_pkg::CFG_SPACING, spc_set[ph]);
      write_reg(ncs_pkg::CFG_FIRST, first_set[ph]);
      for (int n = 0; n < 390; n++) begin
        push_random();
        if (n == 200) begin
          // let everything in flight finish before going on
          wait (pending_items.size() == 0 && !start && expected_results.size() == 0);
        end
      end
      wait_drained();
    end

    repeat (200) @(posedge clk);
    $display("Checked %0d results over %0d solves: %0d ok, %0d extrapolated,",
             checked, solves, n_ok, n_extrap);
    $display("  %0d below range, %0d unsolved; %0d mismatches",
             n_below, n_unsolved, mismatches);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
